// ===== hw/rtl/radius_connected_point_clustering_core_macros.svh =====
// assertion helpers for the clustering core
`ifndef RADIUS_CONNECTED_POINT_CLUSTERING_CORE_MACROS_SVH
`define RADIUS_CONNECTED_POINT_CLUSTERING_CORE_MACROS_SVH

`define RCPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define RCPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rcpc_pkg.sv =====
package rcpc_pkg;

  localparam int unsigned MaxPointsDef = 4096;
  localparam int unsigned CoordBitsDef = 16;

  localparam int unsigned FieldCoordW = 16;
  localparam int unsigned FieldIdxW   = 12;
  localparam int unsigned FieldSizeW  = 13;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [15:0] RadiusRst  = 16'd200;
  localparam logic [12:0] MinSizeRst = 13'd3;
  localparam logic [12:0] MaxSizeRst = 13'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_MIN_SIZE = 2'd1,
    CFG_MAX_SIZE = 2'd2
  } cfg_idx_e;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_LABEL   = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [FieldCoordW-1:0] x_cm;
    logic [FieldCoordW-1:0] y_cm;
    logic [FieldCoordW-1:0] z_cm;
    logic                   frame_end;
    logic [FieldIdxW-1:0]   query_index;
  } in_item_t;

  typedef struct packed {
    logic                  result_kind;
    logic [FieldIdxW-1:0]  point_index;
    logic [FieldIdxW-1:0]  cluster_id;
    logic [FieldSizeW-1:0] cluster_size;
    logic                  kept;
    logic [FieldSizeW-1:0] cluster_count;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic clr;
    logic acc_en;
  } sq_ctrl_t;

endpackage

// ===== hw/rtl/rcpc_if.sv =====
interface rcpc_in_if;
  logic               valid;
  logic               ready;
  rcpc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcpc_out_if;
  logic                valid;
  logic                ready;
  rcpc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rcpc_sq_unit.sv =====
module rcpc_sq_unit #(
  parameter int unsigned MW = 17
) (
  input  logic                clk_i,
  input  rcpc_pkg::sq_ctrl_t  ctrl_i,
  input  logic [MW-1:0]       a_i,
  output logic [2*MW-1:0]     prod_o,
  output logic [2*MW+1:0]     acc_o
);
  import rcpc_pkg::*;

  logic [2*MW-1:0] prod_q;
  logic [2*MW+1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl_i.mul_en) prod_q <= a_i * a_i;
      if (ctrl_i.acc_en) acc_q <= acc_q + (2*MW+2)'(prod_q);
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;
endmodule

// ===== hw/rtl/radius_connected_point_clustering_core.sv =====
// Clustering core. Point loads are taken one per cycle while the core is idle. The
// load marked frame_end starts clustering of the frame of n points, during which the
// core is not ready: a clearing pass over the visited marks, squaring of the radius,
// a check of every seed index, then for every point popped from the seed queue a
// fetch of that point and a brute-force scan of all n points through the single
// shared squaring unit, with the squaring skipped for a point already visited, and
// then labeling of every point in the cluster. A read fetches the label and cluster
// size of its point and then emits the result.
`include "radius_connected_point_clustering_core_macros.svh"

module radius_connected_point_clustering_core #(
  parameter int unsigned MAX_POINTS = rcpc_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = rcpc_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rcpc_pkg::CfgDataW-1:0]  cfg_data_i,
  rcpc_in_if.sink                        req_i,
  rcpc_out_if.source                     rsp_o
);
  import rcpc_pkg::*;

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned MW = (COORD_BITS + 1 > 16) ? COORD_BITS + 1 : 16;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned CB = COORD_BITS;

  typedef enum logic [20:0] {
    S_IDLE     = 21'd1 << 0,
    S_CLR      = 21'd1 << 1,
    S_R2       = 21'd1 << 2,
    S_R2B      = 21'd1 << 3,
    S_SEED_RD  = 21'd1 << 4,
    S_SEED_CHK = 21'd1 << 5,
    S_SNEXT    = 21'd1 << 6,
    S_POP_RD   = 21'd1 << 7,
    S_POP_WAIT = 21'd1 << 8,
    S_POP_P    = 21'd1 << 9,
    S_SCAN_RD  = 21'd1 << 10,
    S_SCAN_DIF = 21'd1 << 11,
    S_SQ       = 21'd1 << 12,
    S_ACC      = 21'd1 << 13,
    S_CMP      = 21'd1 << 14,
    S_NJ       = 21'd1 << 15,
    S_LBL_RD   = 21'd1 << 16,
    S_LBL_WR   = 21'd1 << 17,
    S_SUM      = 21'd1 << 18,
    S_QRD      = 21'd1 << 19,
    S_EMIT     = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;

  logic [15:0]       radius_q;
  logic [12:0]       min_q, max_q;
  logic [CW-1:0]     cnt_q, n_q, lab_q, kept_q;
  logic [CW-1:0]     i_q, j_q, head_q, tail_q, k_q;
  logic [1:0]        sq_q;
  logic [IW-1:0]     q_q;
  logic [FieldIdxW-1:0] qf_q;
  logic              kind_q;
  logic [3*CB-1:0]   pc_q;
  logic [MW-1:0]     d_q [3];
  logic [PW-1:0]     r2_q;
  logic              out_vq;
  out_item_t         out_q;

  logic [3*CB-1:0]   pt_mem [MAX_POINTS];
  logic              vis_mem [MAX_POINTS];
  logic [IW-1:0]     lbl_mem [MAX_POINTS];
  logic [CW-1:0]     sz_mem [MAX_POINTS];
  logic [IW-1:0]     que_mem [MAX_POINTS];
  logic [3*CB-1:0]   pt_rd_q;
  logic              vis_rd_q;
  logic [IW-1:0]     lbl_rd_q, que_rd_q;
  logic [CW-1:0]     sz_rd_q;

  logic [IW-1:0]     pt_ra, vis_ra, que_ra;
  logic              vis_we, vis_wd, que_we;
  logic [IW-1:0]     vis_wa, que_wa, que_wd;
  logic              pt_we;
  logic [3*CB-1:0]   pt_wd;

  sq_ctrl_t          sq_ctrl;
  logic [MW-1:0]     sq_a;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     acc;

  logic              acc_in, ld_ok, is_load, cmp_hit, j_last;
  logic [CW-1:0]     cnt_inc;
  logic [31:0]       xz, yz, zz;
  logic [MW-1:0]     dabs [3];

  function automatic logic size_ok(logic [CW-1:0] s, logic [12:0] lo, logic [12:0] hi);
    logic [31:0] top;
    top = (32'(hi) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : 32'(hi);
    return (32'(s) >= 32'(lo)) && (32'(s) <= top);
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign acc_in  = req_i.valid && req_i.ready;
  assign is_load = (req_i.data.func == FUNC_LOAD);
  assign ld_ok   = (cnt_q < CW'(MAX_POINTS));
  assign cnt_inc = ld_ok ? cnt_q + CW'(1) : cnt_q;
  assign j_last  = (j_q == n_q - CW'(1));
  assign cmp_hit = (acc <= AW'(r2_q));

  assign xz = {16'b0, req_i.data.x_cm};
  assign yz = {16'b0, req_i.data.y_cm};
  assign zz = {16'b0, req_i.data.z_cm};
  assign pt_wd = {xz[CB-1:0], yz[CB-1:0], zz[CB-1:0]};
  assign pt_we = acc_in && is_load && ld_ok;

  always_comb begin
    logic [CB:0] a, b, d;
    for (int c = 0; c < 3; c++) begin
      a = {pc_q[c*CB+CB-1], pc_q[c*CB +: CB]};
      b = {pt_rd_q[c*CB+CB-1], pt_rd_q[c*CB +: CB]};
      d = a - b;
      dabs[c] = MW'(d[CB] ? (~d + 1'b1) : d);
    end
  end

  always_comb begin
    pt_ra  = (state_q == S_POP_WAIT) ? que_rd_q : j_q[IW-1:0];
    vis_ra = (state_q == S_SEED_RD) ? i_q[IW-1:0] : j_q[IW-1:0];
    que_ra = (state_q == S_POP_RD) ? head_q[IW-1:0] : k_q[IW-1:0];
    vis_we = 1'b0;
    vis_wa = j_q[IW-1:0];
    vis_wd = 1'b0;
    que_we = 1'b0;
    que_wa = tail_q[IW-1:0];
    que_wd = j_q[IW-1:0];
    if (state_q == S_CLR) begin
      vis_we = 1'b1;
    end else if (state_q == S_SEED_CHK && !vis_rd_q) begin
      vis_we = 1'b1;
      vis_wa = i_q[IW-1:0];
      vis_wd = 1'b1;
      que_we = 1'b1;
      que_wa = '0;
      que_wd = i_q[IW-1:0];
    end else if (state_q == S_CMP && cmp_hit) begin
      vis_we = 1'b1;
      vis_wd = 1'b1;
      que_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[cnt_q[IW-1:0]] <= pt_wd;
    pt_rd_q <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk_i) begin
    if (que_we) que_mem[que_wa] <= que_wd;
    que_rd_q <= que_mem[que_ra];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LBL_WR) begin
      lbl_mem[que_rd_q] <= i_q[IW-1:0];
      sz_mem[que_rd_q]  <= tail_q;
    end
    lbl_rd_q <= lbl_mem[q_q];
    sz_rd_q  <= sz_mem[q_q];
  end

  always_comb begin
    sq_ctrl = '0;
    sq_a    = d_q[sq_q];
    unique case (state_q)
      S_R2: begin
        sq_ctrl.mul_en = 1'b1;
        sq_a = MW'(radius_q);
      end
      S_SCAN_DIF: sq_ctrl.clr = 1'b1;
      S_SQ: begin
        sq_ctrl.mul_en = 1'b1;
        sq_ctrl.acc_en = 1'b1;
      end
      S_ACC: sq_ctrl.acc_en = 1'b1;
      default: ;
    endcase
  end

  rcpc_sq_unit #(.MW(MW)) u_sq (
    .clk_i  (clk_i),
    .ctrl_i (sq_ctrl),
    .a_i    (sq_a),
    .prod_o (prod),
    .acc_o  (acc)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          if (is_load) begin
            if (req_i.data.frame_end) state_d = (cnt_inc == '0) ? S_SUM : S_CLR;
          end else if (32'(req_i.data.query_index) < 32'(lab_q)) begin
            state_d = S_QRD;
          end
        end
      end
      S_CLR:      if (j_last) state_d = S_R2;
      S_R2:       state_d = S_R2B;
      S_R2B:      state_d = S_SEED_RD;
      S_SEED_RD:  state_d = S_SEED_CHK;
      S_SEED_CHK: state_d = vis_rd_q ? S_SNEXT : S_POP_RD;
      S_SNEXT:    state_d = (i_q == n_q - CW'(1)) ? S_SUM : S_SEED_RD;
      S_POP_RD:   state_d = S_POP_WAIT;
      S_POP_WAIT: state_d = S_POP_P;
      S_POP_P:    state_d = S_SCAN_RD;
      S_SCAN_RD:  state_d = S_SCAN_DIF;
      S_SCAN_DIF: state_d = vis_rd_q ? S_NJ : S_SQ;
      S_SQ:       if (sq_q == 2'd2) state_d = S_ACC;
      S_ACC:      state_d = S_CMP;
      S_CMP:      state_d = S_NJ;
      S_NJ: begin
        if (!j_last) state_d = S_SCAN_RD;
        else if (head_q + CW'(1) < tail_q) state_d = S_POP_RD;
        else state_d = S_LBL_RD;
      end
      S_LBL_RD:   state_d = S_LBL_WR;
      S_LBL_WR:   state_d = (k_q + CW'(1) == tail_q) ? S_SNEXT : S_LBL_RD;
      S_SUM:      state_d = S_EMIT;
      S_QRD:      state_d = S_EMIT;
      S_EMIT:     if (!out_vq || rsp_o.ready) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      radius_q <= RadiusRst;
      min_q    <= MinSizeRst;
      max_q    <= MaxSizeRst;
      cnt_q    <= '0;
      n_q      <= '0;
      lab_q    <= '0;
      kept_q   <= '0;
      i_q      <= '0;
      j_q      <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      k_q      <= '0;
      sq_q     <= '0;
      out_vq   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIUS:   radius_q <= cfg_data_i;
          CFG_MIN_SIZE: min_q <= cfg_data_i[12:0];
          CFG_MAX_SIZE: max_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (state_q == S_EMIT && (!out_vq || rsp_o.ready)) out_vq <= 1'b1;
      else if (out_vq && rsp_o.ready) out_vq <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc_in && is_load) begin
            cnt_q <= cnt_inc;
            if (req_i.data.frame_end) begin
              n_q    <= cnt_inc;
              j_q    <= '0;
              i_q    <= '0;
              kept_q <= '0;
            end
          end
        end
        S_CLR: j_q <= j_q + CW'(1);
        S_SEED_CHK: begin
          if (!vis_rd_q) begin
            head_q <= '0;
            tail_q <= CW'(1);
          end
        end
        S_SNEXT: i_q <= i_q + CW'(1);
        S_POP_P: j_q <= '0;
        S_SCAN_DIF: sq_q <= '0;
        S_SQ: sq_q <= sq_q + 2'd1;
        S_CMP: if (cmp_hit) tail_q <= tail_q + CW'(1);
        S_NJ: begin
          if (!j_last) begin
            j_q <= j_q + CW'(1);
          end else begin
            head_q <= head_q + CW'(1);
            k_q    <= '0;
          end
        end
        S_LBL_WR: begin
          k_q <= k_q + CW'(1);
          if (k_q + CW'(1) == tail_q && size_ok(tail_q, min_q, max_q)) begin
            kept_q <= kept_q + CW'(1);
          end
        end
        S_SUM: begin
          lab_q <= n_q;
          cnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && acc_in) begin
      q_q    <= IW'(req_i.data.query_index);
      qf_q   <= req_i.data.query_index;
      kind_q <= is_load ? KIND_SUMMARY : KIND_LABEL;
    end
    if (state_q == S_POP_P) pc_q <= pt_rd_q;
    if (state_q == S_SCAN_DIF) begin
      for (int c = 0; c < 3; c++) d_q[c] <= dabs[c];
    end
    if (state_q == S_R2B) r2_q <= prod;
    if (state_q == S_EMIT && (!out_vq || rsp_o.ready)) begin
      out_q.result_kind   <= kind_q;
      out_q.cluster_count <= FieldSizeW'(kept_q);
      if (kind_q == KIND_LABEL) begin
        out_q.point_index  <= qf_q;
        out_q.cluster_id   <= FieldIdxW'(lbl_rd_q);
        out_q.cluster_size <= FieldSizeW'(sz_rd_q);
        out_q.kept         <= size_ok(sz_rd_q, min_q, max_q);
      end else begin
        out_q.point_index  <= '0;
        out_q.cluster_id   <= '0;
        out_q.cluster_size <= '0;
        out_q.kept         <= 1'b0;
      end
    end
  end

  assign rsp_o.valid = out_vq;
  assign rsp_o.data  = out_q;

  `RCPC_ASSERT_IMP(a_head_tail, state_q == S_SCAN_RD, head_q < tail_q, "head passed tail")
  `RCPC_ASSERT_IMP(a_tail_n, state_q == S_CMP, tail_q <= n_q, "seed queue overrun")
  `RCPC_ASSERT_NXT(a_frame_go, acc_in && is_load && req_i.data.frame_end && cnt_inc != '0, state_q == S_CLR, "frame end did not start clustering")
endmodule
